// ===== design/button_debounce_chord_detector_defines.svh =====
// Assertion macros used by the checker file of the button debounce block.
`ifndef BUTTON_DEBOUNCE_CHORD_DETECTOR_DEFINES_SVH
`define BUTTON_DEBOUNCE_CHORD_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bdc_pkg.sv =====
// Types and constants of the button debounce and chord detector.
`timescale 1ns / 1ps

package bdc_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);
  localparam int CFG_TIME_W  = 16;
  localparam int NOW_W       = 32;
  localparam int CFG_IDX_W   = 3;

  typedef logic [NUM_BUTTONS-1:0] btn_mask_t;
  typedef logic [BTN_IDX_W-1:0]   btn_idx_t;
  typedef logic [CFG_TIME_W-1:0]  cfg_time_t;

  typedef enum logic [1:0] {
    OP_POLL        = 2'd0,
    OP_RESYNC_ALL  = 2'd1,
    OP_RESYNC_LAST = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_BUTTON    = 3'd1,
    EV_HOLD      = 3'd2,
    EV_BACKSLASH = 3'd3,
    EV_SLASH     = 3'd4
  } event_kind_t;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DEBOUNCE   = 3'd0;
  localparam cfg_idx_t REG_LONG_PRESS = 3'd1;
  localparam cfg_idx_t REG_CHORD_HOLD = 3'd2;
  localparam cfg_idx_t REG_BACKSLASH  = 3'd3;
  localparam cfg_idx_t REG_SLASH      = 3'd4;

  localparam cfg_time_t DEBOUNCE_RST   = 16'd30;
  localparam cfg_time_t LONG_PRESS_RST = 16'd800;
  localparam cfg_time_t CHORD_HOLD_RST = 16'd1000;
  localparam btn_mask_t BACKSLASH_RST  = 4'd10;
  localparam btn_mask_t SLASH_RST      = 4'd5;

  localparam btn_idx_t LAST_BUTTON = BTN_IDX_W'(NUM_BUTTONS - 1);

endpackage

// ===== design/button_debounce_chord_detector.sv =====
// Top level of the four-button debouncer with long-press and chord detection.
//
//   channel | direction | tdata / data                        | tuser
//   in_     | slave     | now_ms[31:0], pressed_bits[35:32]    | opcode[1:0]
//   out_    | master    | button_number, long, stable, service | event_kind[2:0]
//   cfg_    | slave     | cfg_index selects, cfg_data[15:0]    | -
//
// One item per cycle sustained while out_tready stays high. An in_ transfer goes
// into the input register, then through one pass of debounce, chord and pending
// logic into the result register. All state updates happen in that single pass.
// Synchronous active-low reset clears the block state and valid flags and loads the register defaults.
// out_tready low holds the result register; the input register still takes one
// item, after which in_tready drops until the result is taken. cfg_ready is always high.
`timescale 1ns / 1ps

module button_debounce_chord_detector #(
  parameter int TIME_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,   // now_ms, pressed_bits, zero fill
  input  logic [1:0]                   in_tuser,   // opcode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // button_number, long_flag, stable_bits,
                                                   // service_needed
  output logic [2:0]                   out_tuser,  // event_kind
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdc_pkg::CFG_TIME_W-1:0] cfg_data
);

  localparam int NB = bdc_pkg::NUM_BUTTONS;

  typedef logic [TIME_BITS-1:0] tm_t;

  // configuration
  bdc_pkg::cfg_time_t debounce_r, long_press_r, chord_hold_r;
  bdc_pkg::btn_mask_t backslash_r, slash_r;

  // input register
  logic                s1_valid_r;
  bdc_pkg::opcode_t    s1_op_r;
  tm_t                 s1_now_r;
  bdc_pkg::btn_mask_t  s1_bits_r;
  logic                s1_adv;

  // block state
  bdc_pkg::btn_mask_t  raw_r, raw_nxt, stable_r, stable_nxt;
  tm_t                 change_time_r [NB];
  tm_t                 change_time_nxt [NB];
  tm_t                 press_time_r [NB];
  tm_t                 press_time_nxt [NB];
  bdc_pkg::btn_mask_t  pend_rel_r, pend_rel_nxt, pend_long_r, pend_long_nxt;
  bdc_pkg::btn_mask_t  active_r, active_nxt, suppress_r, suppress_nxt;
  tm_t                 chord_start_r, chord_start_nxt;
  logic                hold_rep_r, hold_rep_nxt;

  // result
  bdc_pkg::event_kind_t kind;
  bdc_pkg::btn_idx_t    num;
  logic                 lng;
  logic                 svc;

  logic                 out_valid_r;
  bdc_pkg::event_kind_t out_kind_r;
  bdc_pkg::btn_idx_t    out_num_r;
  logic                 out_long_r;
  bdc_pkg::btn_mask_t   out_stable_r;
  logic                 out_svc_r;

  function automatic bdc_pkg::btn_idx_t lowest_set(input bdc_pkg::btn_mask_t m);
    bdc_pkg::btn_idx_t idx;
    idx = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = bdc_pkg::BTN_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= bdc_pkg::DEBOUNCE_RST;
      long_press_r <= bdc_pkg::LONG_PRESS_RST;
      chord_hold_r <= bdc_pkg::CHORD_HOLD_RST;
      backslash_r  <= bdc_pkg::BACKSLASH_RST;
      slash_r      <= bdc_pkg::SLASH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bdc_pkg::REG_DEBOUNCE:   debounce_r   <= cfg_data;
        bdc_pkg::REG_LONG_PRESS: long_press_r <= cfg_data;
        bdc_pkg::REG_CHORD_HOLD: chord_hold_r <= cfg_data;
        bdc_pkg::REG_BACKSLASH:  backslash_r  <= cfg_data[NB-1:0];
        bdc_pkg::REG_SLASH:      slash_r      <= cfg_data[NB-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= bdc_pkg::opcode_t'(in_tuser);
      s1_now_r  <= in_tdata[TIME_BITS-1:0];
      s1_bits_r <= in_tdata[bdc_pkg::NOW_W +: NB];
    end
  end

  always_comb begin
    bdc_pkg::btn_mask_t released, released_long, suppressed, sm;
    tm_t                 dt;
    tm_t                 chord_dt;
    logic                p;
    raw_nxt         = raw_r;
    stable_nxt      = stable_r;
    change_time_nxt = change_time_r;
    press_time_nxt  = press_time_r;
    pend_rel_nxt    = pend_rel_r;
    pend_long_nxt   = pend_long_r;
    active_nxt      = active_r;
    suppress_nxt    = suppress_r;
    chord_start_nxt = chord_start_r;
    hold_rep_nxt    = hold_rep_r;
    kind            = bdc_pkg::EV_NONE;
    num             = '0;
    lng             = 1'b0;
    released        = '0;
    released_long   = '0;
    suppressed      = '0;
    sm              = '0;
    dt              = '0;
    chord_dt        = '0;
    p               = 1'b0;
    case (s1_op_r)
      bdc_pkg::OP_POLL: begin
        if (|pend_rel_r) begin
          num                = lowest_set(pend_rel_r);
          kind               = bdc_pkg::EV_BUTTON;
          lng                = pend_long_r[num];
          pend_rel_nxt[num]  = 1'b0;
          pend_long_nxt[num] = 1'b0;
        end else begin
          for (int i = 0; i < NB; i++) begin
            p  = s1_bits_r[i];
            dt = s1_now_r - change_time_r[i];
            if (p != raw_r[i]) begin
              raw_nxt[i]         = p;
              change_time_nxt[i] = s1_now_r;
              dt                 = '0;
            end
            if (p != stable_r[i] && dt >= TIME_BITS'(debounce_r)) begin
              stable_nxt[i] = p;
              if (p) begin
                press_time_nxt[i] = s1_now_r;
              end else begin
                released[i]      = 1'b1;
                released_long[i] = (s1_now_r - press_time_r[i]) >= TIME_BITS'(long_press_r);
              end
            end
          end
          sm = stable_nxt;
          if (active_r == '0) begin
            if ((sm & backslash_r) == backslash_r) begin
              active_nxt = backslash_r;
            end else if ((sm & slash_r) == slash_r) begin
              active_nxt = slash_r;
            end
            if (active_nxt != '0) begin
              suppress_nxt    = active_nxt;
              chord_start_nxt = s1_now_r;
              hold_rep_nxt    = 1'b0;
            end
          end
          chord_dt = s1_now_r - chord_start_nxt;
          if (active_nxt != '0 && !hold_rep_nxt && chord_dt >= TIME_BITS'(chord_hold_r)) begin
            hold_rep_nxt = 1'b1;
            kind         = bdc_pkg::EV_HOLD;
          end
          suppressed = suppress_nxt;
          if (active_nxt != '0 && (sm & active_nxt) == '0) begin
            kind = (active_nxt == backslash_r) ? bdc_pkg::EV_BACKSLASH : bdc_pkg::EV_SLASH;
            lng          = chord_dt >= TIME_BITS'(chord_hold_r);
            active_nxt   = '0;
            suppress_nxt = '0;
          end
          pend_rel_nxt  = released & ~suppressed;
          pend_long_nxt = pend_long_r | (released_long & ~suppressed);
          if (kind == bdc_pkg::EV_NONE && |pend_rel_nxt) begin
            num                = lowest_set(pend_rel_nxt);
            kind               = bdc_pkg::EV_BUTTON;
            lng                = pend_long_nxt[num];
            pend_rel_nxt[num]  = 1'b0;
            pend_long_nxt[num] = 1'b0;
          end
        end
      end
      bdc_pkg::OP_RESYNC_ALL: begin
        raw_nxt    = s1_bits_r;
        stable_nxt = s1_bits_r;
        for (int i = 0; i < NB; i++) begin
          change_time_nxt[i] = s1_now_r;
          press_time_nxt[i]  = s1_now_r;
        end
      end
      bdc_pkg::OP_RESYNC_LAST: begin
        raw_nxt[bdc_pkg::LAST_BUTTON]         = s1_bits_r[bdc_pkg::LAST_BUTTON];
        stable_nxt[bdc_pkg::LAST_BUTTON]      = s1_bits_r[bdc_pkg::LAST_BUTTON];
        change_time_nxt[bdc_pkg::LAST_BUTTON] = s1_now_r;
        press_time_nxt[bdc_pkg::LAST_BUTTON]  = s1_now_r;
      end
      default: ;
    endcase
    svc = (active_nxt != '0) || (pend_rel_nxt != '0) || (pend_long_nxt != '0) ||
          (raw_nxt != '0) || (stable_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r         <= '0;
      stable_r      <= '0;
      pend_rel_r    <= '0;
      pend_long_r   <= '0;
      active_r      <= '0;
      suppress_r    <= '0;
      chord_start_r <= '0;
      hold_rep_r    <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        change_time_r[i] <= '0;
        press_time_r[i]  <= '0;
      end
    end else if (s1_adv) begin
      raw_r         <= raw_nxt;
      stable_r      <= stable_nxt;
      pend_rel_r    <= pend_rel_nxt;
      pend_long_r   <= pend_long_nxt;
      active_r      <= active_nxt;
      suppress_r    <= suppress_nxt;
      chord_start_r <= chord_start_nxt;
      hold_rep_r    <= hold_rep_nxt;
      change_time_r <= change_time_nxt;
      press_time_r  <= press_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r   <= kind;
      out_num_r    <= num;
      out_long_r   <= lng;
      out_stable_r <= stable_nxt;
      out_svc_r    <= svc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_svc_r, out_stable_r, out_long_r, out_num_r};

endmodule

// ===== design/bdc_checker.sv =====
// Port-level assertions for the button debounce and chord detector, with bind.
`timescale 1ns / 1ps
`include "button_debounce_chord_detector_defines.svh"

module bdc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser
);

  `BDC_ASSERT_IMP(a_kind_range, out_tvalid, out_tuser <= bdc_pkg::EV_SLASH, "event kind out of range")
  `BDC_ASSERT_IMP(a_num_button_only, out_tvalid && out_tuser != bdc_pkg::EV_BUTTON, out_tdata[1:0] == 2'd0, "button number on non-button event")
  `BDC_ASSERT_IMP(a_long_kind, out_tvalid && (out_tuser == bdc_pkg::EV_NONE || out_tuser == bdc_pkg::EV_HOLD), !out_tdata[2], "long flag on none or hold event")
  `BDC_ASSERT_IMP(a_svc_stable, out_tvalid && out_tdata[6:3] != 4'd0, out_tdata[7], "pressed button without service request")
  `BDC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind button_debounce_chord_detector bdc_checker u_bdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/button_debounce_chord_detector_tb.sv =====
// Self-checking testbench for the button debouncer with long-press and chord detection.
`timescale 1ns / 1ps

module button_debounce_chord_detector_tb;
  import bdc_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    btn_mask_t   bits;
  } button_sample_t;

  typedef struct packed {
    event_kind_t kind;
    btn_idx_t    num;
    logic        lng;
    btn_mask_t   stable;
    logic        svc;
  } debounce_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_TIME_W-1:0] cfg_data = '0;

  button_sample_t in_item = '0;

  assign in_tdata = {4'b0000, in_item.bits, in_item.now};
  assign in_tuser = in_item.op;

  button_debounce_chord_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  button_sample_t   sample_queue[$];
  debounce_result_t due_results[$];
  int mismatches = 0;
  logic in_done = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_cycles = 0;
  logic [31:0] t_now = '0;

  // Predictor state and register copy
  cfg_time_t   c_debounce, c_long, c_hold;
  btn_mask_t   c_bslash, c_slash;
  btn_mask_t   m_raw, m_stable, m_pend_rel, m_pend_long, m_chord, m_suppress;
  logic [31:0] m_chg[NUM_BUTTONS];
  logic [31:0] m_press[NUM_BUTTONS];
  logic [31:0] m_chord_t0;
  logic        m_hold_done;

  task automatic reset_model();
    c_debounce = DEBOUNCE_RST;
    c_long = LONG_PRESS_RST;
    c_hold = CHORD_HOLD_RST;
    c_bslash = BACKSLASH_RST;
    c_slash = SLASH_RST;
    m_raw = '0;
    m_stable = '0;
    m_pend_rel = '0;
    m_pend_long = '0;
    m_chord = '0;
    m_suppress = '0;
    m_chord_t0 = '0;
    m_hold_done = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      m_chg[i] = '0;
      m_press[i] = '0;
    end
  endtask

  task automatic apply_reg(input cfg_idx_t idx, input logic [15:0] d);
    case (idx)
      REG_DEBOUNCE:   c_debounce = d;
      REG_LONG_PRESS: c_long = d;
      REG_CHORD_HOLD: c_hold = d;
      REG_BACKSLASH:  c_bslash = d[NUM_BUTTONS-1:0];
      REG_SLASH:      c_slash = d[NUM_BUTTONS-1:0];
      default: ;
    endcase
  endtask

  task automatic pop_release(inout debounce_result_t r, output logic got);
    got = 1'b0;
    for (int i = 0; i < NUM_BUTTONS && !got; i++) begin
      if (m_pend_rel[i]) begin
        m_pend_rel[i] = 1'b0;
        r.kind = EV_BUTTON;
        r.num = btn_idx_t'(i);
        r.lng = m_pend_long[i];
        m_pend_long[i] = 1'b0;
        got = 1'b1;
      end
    end
  endtask

  task automatic resync_button(input int i, input btn_mask_t bits, input logic [31:0] now);
    m_raw[i] = bits[i];
    m_stable[i] = bits[i];
    m_chg[i] = now;
    m_press[i] = now;
  endtask

  task automatic step_buttons(input button_sample_t s, output debounce_result_t r);
    btn_mask_t rel, rel_long, sm, supp;
    logic got;
    r = '0;
    r.kind = EV_NONE;
    rel = '0;
    rel_long = '0;
    case (s.op)
      OP_POLL: begin
        pop_release(r, got);
        if (!got) begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (s.bits[i] != m_raw[i]) begin
              m_raw[i] = s.bits[i];
              m_chg[i] = s.now;
            end
            if (s.bits[i] != m_stable[i] && (s.now - m_chg[i]) >= 32'(c_debounce)) begin
              m_stable[i] = s.bits[i];
              if (s.bits[i]) begin
                m_press[i] = s.now;
              end else begin
                rel[i] = 1'b1;
                if ((s.now - m_press[i]) >= 32'(c_long)) rel_long[i] = 1'b1;
              end
            end
          end
          sm = m_stable;
          if (m_chord == '0) begin
            if ((sm & c_bslash) == c_bslash) m_chord = c_bslash;
            else if ((sm & c_slash) == c_slash) m_chord = c_slash;
            if (m_chord != '0) begin
              m_suppress = m_chord;
              m_chord_t0 = s.now;
              m_hold_done = 1'b0;
            end
          end
          if (m_chord != '0 && !m_hold_done && (s.now - m_chord_t0) >= 32'(c_hold)) begin
            m_hold_done = 1'b1;
            r.kind = EV_HOLD;
          end
          supp = m_suppress;
          if (m_chord != '0 && (sm & m_chord) == '0) begin
            r.kind = (m_chord == c_bslash) ? EV_BACKSLASH : EV_SLASH;
            r.lng = (s.now - m_chord_t0) >= 32'(c_hold);
            m_chord = '0;
            m_suppress = '0;
          end
          m_pend_rel = m_pend_rel | (rel & ~supp);
          m_pend_long = m_pend_long | (rel_long & ~supp);
          if (r.kind == EV_NONE) pop_release(r, got);
        end
      end
      OP_RESYNC_ALL: begin
        for (int i = 0; i < NUM_BUTTONS; i++) resync_button(i, s.bits, s.now);
      end
      OP_RESYNC_LAST: resync_button(int'(LAST_BUTTON), s.bits, s.now);
      default: ;
    endcase
    r.stable = m_stable;
    r.svc = (m_chord != '0) || (m_pend_rel != '0) || (m_pend_long != '0) ||
            (m_raw != '0) || (m_stable != '0);
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at %0t: %s got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Predict on input transfer, check on output transfer
  always @(posedge clk) begin : monitor
    debounce_result_t predicted, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        step_buttons(in_item, predicted);
        due_results.push_back(predicted);
        in_done = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result", int'(out_tdata), 0);
        end else begin
          want = due_results.pop_front();
          if (out_tuser != want.kind) flag_mismatch("event_kind", out_tuser, want.kind);
          if (out_tdata[1:0] != want.num) flag_mismatch("button_number", out_tdata[1:0], want.num);
          if (out_tdata[2] != want.lng) flag_mismatch("long_flag", out_tdata[2], want.lng);
          if (out_tdata[6:3] != want.stable)
            flag_mismatch("stable_bits", out_tdata[6:3], want.stable);
          if (out_tdata[7] != want.svc) flag_mismatch("service_needed", out_tdata[7], want.svc);
        end
      end
    end
  end

  always @(negedge clk) begin : sender
    logic nv;
    button_sample_t ni;
    nv = in_tvalid;
    ni = in_item;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_tvalid || in_done) begin
      in_done = 1'b0;
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (sample_queue.size() > 0) begin
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(1, 11) - 1;
        end else begin
          ni = sample_queue.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_tvalid <= nv;
    in_item <= ni;
  end

  always @(negedge clk) begin : receiver
    logic nr;
    nr = 1'b1;
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        nr = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        nr = 1'b0;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(1, 11) - 1;
        nr = 1'b0;
      end
    end
    out_tready <= nr;
  end

  task automatic push_sample(input logic [1:0] op, input logic [31:0] now, input btn_mask_t bits);
    button_sample_t s;
    s.op = op;
    s.now = now;
    s.bits = bits;
    sample_queue.push_back(s);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Press patterns built around the current chord masks, with bounce and resyncs mixed in
  task automatic add_presses(input int count, input int unsigned max_step);
    btn_mask_t held, bits;
    int hold_left, pick;
    logic [1:0] op;
    held = '0;
    hold_left = 0;
    for (int k = 0; k < count; k++) begin
      if (hold_left == 0) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1:    held = c_bslash;
          2, 3:    held = c_slash;
          4, 5, 6: held = '0;
          7:       held = btn_mask_t'(1 << $urandom_range(0, NUM_BUTTONS - 1));
          8:       held = btn_mask_t'($urandom);
          default: held = held | c_bslash;
        endcase
        hold_left = $urandom_range(1, 12);
      end
      hold_left--;
      pick = $urandom_range(0, 99);
      if (pick < 8) t_now = t_now + $urandom_range(0, 4 * max_step);
      else t_now = t_now + $urandom_range(0, max_step);
      if (pick == 99) t_now = $urandom;
      bits = held;
      if ($urandom_range(0, 99) < 10) bits[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 90) op = OP_POLL;
      else if (pick < 94) op = OP_RESYNC_ALL;
      else if (pick < 98) op = OP_RESYNC_LAST;
      else op = OP_RESERVED;
      push_sample(op, t_now, bits);
    end
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_sample(OP_POLL, 32'd0, 4'h0);
    push_sample(OP_RESERVED, 32'hFFFF_FFFF, 4'hF);
    push_sample(OP_RESYNC_ALL, 32'd100, 4'hF);
    push_sample(OP_POLL, 32'd100, 4'hF);
    push_sample(OP_POLL, 32'd1200, 4'hF);
    push_sample(OP_POLL, 32'd1210, 4'h0);
    push_sample(OP_POLL, 32'd1240, 4'h0);
    push_sample(OP_POLL, 32'd1241, 4'h0);
    push_sample(OP_POLL, 32'd1242, 4'h0);
    push_sample(OP_RESYNC_LAST, 32'd1300, 4'h8);
    push_sample(OP_POLL, 32'd1300, 4'h8);
    push_sample(OP_POLL, 32'd1400, 4'h0);
    push_sample(OP_POLL, 32'd1430, 4'h0);
    push_sample(OP_POLL, 32'd2000, 4'h5);
    push_sample(OP_POLL, 32'd2030, 4'h5);
    push_sample(OP_POLL, 32'd2500, 4'h0);
    push_sample(OP_POLL, 32'd3100, 4'h0);
    push_sample(OP_POLL, 32'hFFFF_FFE0, 4'h2);
    push_sample(OP_POLL, 32'hFFFF_FFFF, 4'h2);
    push_sample(OP_POLL, 32'h0000_0010, 4'h0);
    push_sample(OP_POLL, 32'h0000_0400, 4'h0);
    push_sample(OP_POLL, 32'h0000_0400, 4'h0);
    push_sample(OP_RESYNC_ALL, 32'h0000_0500, 4'hA);
    push_sample(OP_POLL, 32'h0000_0500, 4'hA);
    push_sample(OP_RESYNC_ALL, 32'h0000_0600, 4'h0);
    push_sample(OP_POLL, 32'h0000_0601, 4'h0);
    wait_drained();

    // Stall the receiver long enough to back up the input
    in_idle_pct = 30;
    out_idle_pct = 30;
    t_now = 32'd5000;
    hold_cycles = 80;
    add_presses(250, 150);
    wait_drained();

    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_LONG_PRESS, 16'd0);
    write_reg(REG_CHORD_HOLD, 16'd0);
    write_reg(REG_BACKSLASH, 16'hFFF0);
    write_reg(REG_SLASH, 16'd15);
    add_presses(200, 20);
    wait_drained();

    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    write_reg(REG_CHORD_HOLD, 16'hFFFF);
    write_reg(REG_BACKSLASH, 16'hFFFF);
    write_reg(REG_SLASH, 16'h0003);
    t_now = $urandom;
    add_presses(200, 30000);
    wait_drained();

    in_idle_pct = 50;
    out_idle_pct = 0;
    write_reg(REG_DEBOUNCE, 16'($urandom_range(1, 60)));
    write_reg(REG_LONG_PRESS, 16'($urandom_range(50, 900)));
    write_reg(REG_CHORD_HOLD, 16'($urandom_range(100, 1200)));
    write_reg(REG_BACKSLASH, 16'($urandom_range(1, 15)));
    write_reg(REG_SLASH, 16'(c_bslash));
    add_presses(200, 150);
    wait_drained();

    in_idle_pct = 0;
    out_idle_pct = 50;
    write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 200)));
    write_reg(REG_LONG_PRESS, 16'($urandom));
    write_reg(REG_CHORD_HOLD, 16'($urandom_range(0, 3000)));
    write_reg(REG_BACKSLASH, 16'($urandom));
    write_reg(REG_SLASH, 16'($urandom));
    t_now = 32'hFFFF_F000;
    add_presses(200, 300);
    wait_drained();

    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(REG_DEBOUNCE, DEBOUNCE_RST);
    write_reg(REG_LONG_PRESS, LONG_PRESS_RST);
    write_reg(REG_CHORD_HOLD, CHORD_HOLD_RST);
    write_reg(REG_BACKSLASH, 16'(BACKSLASH_RST));
    write_reg(REG_SLASH, 16'(SLASH_RST));
    add_presses(180, 150);
    wait_drained();

    repeat (10) @(posedge clk);
    if (due_results.size() != 0) flag_mismatch("results never delivered", due_results.size(), 0);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
